// File: hw/rtl/lewcd_pkg.sv
// ----------------------------------------------------------------------------
// lewcd_pkg
// Shared types, codes and reset values for the indicator edge-window decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lewcd_pkg;

    // item command codes
    typedef enum logic [1:0] {
        CMD_HOUSEKEEP = 2'd0,
        CMD_LEVEL     = 2'd1,
        CMD_BEACON    = 2'd2,
        CMD_UNUSED    = 2'd3
    } cmd_t;

    // result action codes
    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_SCROLL     = 3'd1,
        ACT_RESOLUTION = 3'd2,
        ACT_BOOT       = 3'd3,
        ACT_BEACON     = 3'd4
    } action_t;

    // register map, index = byte address >> REG_ADDR_LSB
    localparam int unsigned REG_ADDR_LSB = 2;
    localparam int unsigned REG_IDX_W    = 3;
    localparam int unsigned PADDR_W      = REG_ADDR_LSB + REG_IDX_W;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ACCEPT_COMMANDS = 3'd0,
        REG_BEACON_ENABLE   = 3'd1,
        REG_WINDOW_MS       = 3'd2,
        REG_GUARD_MS        = 3'd3,
        REG_COOLDOWN_MS     = 3'd4
    } reg_idx_t;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned DUR_W   = 16;
    localparam int unsigned COUNT_W = 8;

    localparam logic [DUR_W-1:0] WINDOW_MS_RST   = 16'd120;
    localparam logic [DUR_W-1:0] GUARD_MS_RST    = 16'd250;
    localparam logic [DUR_W-1:0] COOLDOWN_MS_RST = 16'd300;

    localparam logic [COUNT_W-1:0] COUNT_SCROLL     = 8'd2;
    localparam logic [COUNT_W-1:0] COUNT_RESOLUTION = 8'd4;
    localparam logic [COUNT_W-1:0] COUNT_BOOT       = 8'd6;

    function automatic action_t decode_count(input logic [COUNT_W-1:0] count);
        action_t act;
        case (count)
            COUNT_SCROLL:     act = ACT_SCROLL;
            COUNT_RESOLUTION: act = ACT_RESOLUTION;
            COUNT_BOOT:       act = ACT_BOOT;
            default:          act = ACT_NONE;
        endcase
        return act;
    endfunction

    // true when (now - then) mod 2^32 has reached dur
    function automatic logic elapsed(input logic [TIME_W-1:0] now,
                                     input logic [TIME_W-1:0] then,
                                     input logic [DUR_W-1:0]  dur);
        logic [TIME_W-1:0] diff;
        diff = now - then;
        return diff >= {{(TIME_W-DUR_W){1'b0}}, dur};
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/led_edge_window_command_decoder.sv
// ----------------------------------------------------------------------------
// led_edge_window_command_decoder
// Turns host level reports on an indicator into commands and beacon requests.
// ----------------------------------------------------------------------------
// One beat in gives exactly one action beat out. A beat is taken into an input
// register, decoded combinationally against the window, guard and cooldown state
// with compares on 32-bit timestamp differences, and placed in an output
// register; state updates in that same cycle, so a new beat can be taken every
// clock. The action is offered from the output register, which follows the input
// register. Throughput is one beat per cycle; it drops only while out_stall
// holds the output register full. Registers sit on an APB-style port at byte
// address 4*index and should only be written while no beat is in flight.
`default_nettype none

module led_edge_window_command_decoder (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lewcd_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    // item input
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [1:0]                      cmd,
    input  wire logic [31:0]                     now_ms,
    input  wire logic                            level,
    // result output
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [2:0]                      action
);

    // ---------------- configuration registers ----------------
    logic                               accept_commands_reg;
    logic                               beacon_enable_reg;
    logic [lewcd_pkg::DUR_W-1:0]        window_ms_reg;
    logic [lewcd_pkg::DUR_W-1:0]        guard_ms_reg;
    logic [lewcd_pkg::DUR_W-1:0]        cooldown_ms_reg;

    lewcd_pkg::reg_idx_t                reg_idx;
    logic                               cfg_write;

    assign reg_idx   = lewcd_pkg::reg_idx_t'(
                           paddr[lewcd_pkg::PADDR_W-1:lewcd_pkg::REG_ADDR_LSB]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_commands_reg <= 1'b1;
            beacon_enable_reg   <= 1'b0;
            window_ms_reg       <= lewcd_pkg::WINDOW_MS_RST;
            guard_ms_reg        <= lewcd_pkg::GUARD_MS_RST;
            cooldown_ms_reg     <= lewcd_pkg::COOLDOWN_MS_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                lewcd_pkg::REG_ACCEPT_COMMANDS: accept_commands_reg <= pwdata[0];
                lewcd_pkg::REG_BEACON_ENABLE:   beacon_enable_reg   <= pwdata[0];
                lewcd_pkg::REG_WINDOW_MS:
                    window_ms_reg   <= pwdata[lewcd_pkg::DUR_W-1:0];
                lewcd_pkg::REG_GUARD_MS:
                    guard_ms_reg    <= pwdata[lewcd_pkg::DUR_W-1:0];
                lewcd_pkg::REG_COOLDOWN_MS:
                    cooldown_ms_reg <= pwdata[lewcd_pkg::DUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            lewcd_pkg::REG_ACCEPT_COMMANDS: prdata = {31'd0, accept_commands_reg};
            lewcd_pkg::REG_BEACON_ENABLE:   prdata = {31'd0, beacon_enable_reg};
            lewcd_pkg::REG_WINDOW_MS:       prdata = {16'd0, window_ms_reg};
            lewcd_pkg::REG_GUARD_MS:        prdata = {16'd0, guard_ms_reg};
            lewcd_pkg::REG_COOLDOWN_MS:     prdata = {16'd0, cooldown_ms_reg};
            default:                        prdata = 32'd0;
        endcase
    end

    // ---------------- input register ----------------
    logic                               s1_valid_reg;
    lewcd_pkg::cmd_t                    s1_cmd_reg;
    logic [lewcd_pkg::TIME_W-1:0]       s1_now_reg;
    logic                               s1_level_reg;

    logic                               s2_load;
    logic                               in_take;

    // the output register frees up when empty or when its beat is taken
    assign s2_load  = s1_valid_reg && (!out_valid || !out_stall);
    assign in_stall = s1_valid_reg && !s2_load;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (s2_load)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cmd_reg   <= lewcd_pkg::cmd_t'(cmd);
            s1_now_reg   <= now_ms;
            s1_level_reg <= level;
        end
    end

    // ---------------- decoder state ----------------
    logic                               level_known_reg,  level_known_next;
    logic                               last_level_reg,   last_level_next;
    logic                               window_open_reg,  window_open_next;
    logic [lewcd_pkg::TIME_W-1:0]       window_start_reg, window_start_next;
    logic [lewcd_pkg::COUNT_W-1:0]      edge_count_reg,   edge_count_next;
    logic                               guard_active_reg, guard_active_next;
    logic [lewcd_pkg::TIME_W-1:0]       guard_start_reg,  guard_start_next;
    logic [lewcd_pkg::TIME_W-1:0]       last_beacon_reg,  last_beacon_next;
    lewcd_pkg::action_t                 action_next;

    logic                               window_expired;
    logic                               guard_done;
    logic                               cooldown_done;
    logic                               guard_blocks;

    assign window_expired = window_open_reg &&
        lewcd_pkg::elapsed(s1_now_reg, window_start_reg, window_ms_reg);
    assign guard_done     =
        lewcd_pkg::elapsed(s1_now_reg, guard_start_reg, guard_ms_reg);
    assign cooldown_done  =
        lewcd_pkg::elapsed(s1_now_reg, last_beacon_reg, cooldown_ms_reg);
    assign guard_blocks   = guard_active_reg && !guard_done;

    always_comb
    begin
        level_known_next  = level_known_reg;
        last_level_next   = last_level_reg;
        window_open_next  = window_open_reg;
        window_start_next = window_start_reg;
        edge_count_next   = edge_count_reg;
        guard_active_next = guard_active_reg;
        guard_start_next  = guard_start_reg;
        last_beacon_next  = last_beacon_reg;
        action_next       = lewcd_pkg::ACT_NONE;

        case (s1_cmd_reg)
            lewcd_pkg::CMD_HOUSEKEEP:
            begin
                if (window_expired)
                begin
                    window_open_next = 1'b0;
                    edge_count_next  = '0;
                    if (accept_commands_reg)
                        action_next = lewcd_pkg::decode_count(edge_count_reg);
                end
            end
            lewcd_pkg::CMD_LEVEL:
            begin
                if (!level_known_reg)
                begin
                    // first report only learns the level
                    level_known_next = 1'b1;
                    last_level_next  = s1_level_reg;
                end
                else if (s1_level_reg != last_level_reg)
                begin
                    last_level_next = s1_level_reg;
                    if (guard_active_reg && guard_done)
                        guard_active_next = 1'b0;
                    if (!guard_blocks && accept_commands_reg)
                    begin
                        if (window_expired)
                        begin
                            action_next       = lewcd_pkg::decode_count(edge_count_reg);
                            window_start_next = s1_now_reg;
                            edge_count_next   = lewcd_pkg::COUNT_W'(1);
                        end
                        else
                        begin
                            if (!window_open_reg)
                            begin
                                window_open_next  = 1'b1;
                                window_start_next = s1_now_reg;
                            end
                            edge_count_next = edge_count_reg + lewcd_pkg::COUNT_W'(1);
                        end
                    end
                end
            end
            lewcd_pkg::CMD_BEACON:
            begin
                if (beacon_enable_reg && cooldown_done)
                begin
                    action_next       = lewcd_pkg::ACT_BEACON;
                    last_beacon_next  = s1_now_reg;
                    guard_start_next  = s1_now_reg;
                    guard_active_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_known_reg  <= 1'b0;
            last_level_reg   <= 1'b0;
            window_open_reg  <= 1'b0;
            window_start_reg <= '0;
            edge_count_reg   <= '0;
            guard_active_reg <= 1'b0;
            guard_start_reg  <= '0;
            last_beacon_reg  <= '0;
        end
        else if (s2_load)
        begin
            level_known_reg  <= level_known_next;
            last_level_reg   <= last_level_next;
            window_open_reg  <= window_open_next;
            window_start_reg <= window_start_next;
            edge_count_reg   <= edge_count_next;
            guard_active_reg <= guard_active_next;
            guard_start_reg  <= guard_start_next;
            last_beacon_reg  <= last_beacon_next;
        end
    end

    // ---------------- output register ----------------
    logic                               out_valid_reg;
    lewcd_pkg::action_t                 action_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
            action_reg <= action_next;
    end

    assign out_valid = out_valid_reg;
    assign action    = action_reg;

    // ---------------- assertions ----------------
    // a closed window never carries a count
    a_closed_window_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !window_open_reg |-> (edge_count_reg == '0))
        else $error("edge count nonzero while window closed");

    // once learned, the level stays known
    a_level_known_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        level_known_reg |=> level_known_reg)
        else $error("level_known cleared outside reset");

    // an emitted beacon starts the guard
    a_beacon_starts_guard: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_load && action_next == lewcd_pkg::ACT_BEACON) |=> guard_active_reg)
        else $error("beacon emitted without starting guard");

    // beacons only when enabled
    a_beacon_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_load && action_next == lewcd_pkg::ACT_BEACON) |-> beacon_enable_reg)
        else $error("beacon emitted while disabled");

    // input held off only by a full input register behind a stalled, full output
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked item");

endmodule

`default_nettype wire
